// ===== rtl/twc_pkg.sv =====
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the tilt window classifier
// Field widths, register indexes, class codes, the cordic angle table and
// the conversion of a raw angle to the output unit.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int WINDOW_DEPTH    = 5;
  localparam int SAMPLE_BITS     = 16;
  localparam int ANGLE_FRAC_BITS = 4;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OK_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEADY_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] GOOD_LIMIT_RST   = 12'd160;
  localparam logic [CFG_W-1:0] OK_LIMIT_RST     = 12'd480;
  localparam logic [CFG_W-1:0] STEADY_LIMIT_RST = 12'd32;

  localparam int PITCH_W = 11;
  localparam int ROLL_W  = 12;
  localparam int CLASS_W = 2;
  localparam logic [CLASS_W-1:0] CLASS_GOOD = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_OK   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_BAD  = 2'd2;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int ZW           = 26;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 26'sd5898240;
  localparam logic signed [ZW-1:0] HALF_TURN    = 26'sd11796480;

  localparam int ROUND_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam logic [ZW-1:0] ROUND_HALF = {{(ZW-1){1'b0}}, 1'b1} << (ROUND_SHIFT - 1);

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [ROLL_W-1:0]  roll;
  } item_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 26'sd2949120;
      4'd1:    v = 26'sd1740967;
      4'd2:    v = 26'sd919879;
      4'd3:    v = 26'sd466945;
      4'd4:    v = 26'sd234379;
      4'd5:    v = 26'sd117304;
      4'd6:    v = 26'sd58666;
      4'd7:    v = 26'sd29335;
      4'd8:    v = 26'sd14668;
      4'd9:    v = 26'sd7334;
      4'd10:   v = 26'sd3667;
      4'd11:   v = 26'sd1833;
      4'd12:   v = 26'sd917;
      4'd13:   v = 26'sd458;
      4'd14:   v = 26'sd229;
      4'd15:   v = 26'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up to the output unit
  function automatic logic [ROLL_W-1:0] to_unit(input logic signed [ZW-1:0] z);
    logic [ZW-1:0] u;
    u = $unsigned(z) + ROUND_HALF;
    return ROLL_W'(u >> ROUND_SHIFT);
  endfunction

endpackage

// ===== rtl/twc_in_if.sv =====
// ----------------------------------------------------------------------------
// twc_in_if: sample channel
// Valid/ready channel carrying one signed x, y, z acceleration sample.
// ----------------------------------------------------------------------------
interface twc_in_if #(
  parameter int SAMPLE_BITS = twc_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// ===== rtl/twc_out_if.sv =====
// ----------------------------------------------------------------------------
// twc_out_if: result channel
// Valid/ready channel carrying angles, window level, class and steady flag.
// ----------------------------------------------------------------------------
interface twc_out_if;
  logic                        valid;
  logic                        ready;
  logic [twc_pkg::PITCH_W-1:0] pitch_angle;
  logic [twc_pkg::ROLL_W-1:0]  roll_angle;
  logic [twc_pkg::ROLL_W-1:0]  window_level;
  logic [twc_pkg::CLASS_W-1:0] tilt_class;
  logic                        steady;

  modport source (output valid, output pitch_angle, output roll_angle, output window_level,
                  output tilt_class, output steady, input ready);
  modport sink   (input valid, input pitch_angle, input roll_angle, input window_level,
                  input tilt_class, input steady, output ready);
endinterface

// ===== rtl/twc_front.sv =====
// ----------------------------------------------------------------------------
// twc_front: angle front end
// Accepts a sample, takes the radius by a bit-serial square root and both
// angles by one shared iterative cordic unit, then hands them to the queue.
// ----------------------------------------------------------------------------
module twc_front #(
  parameter int SAMPLE_BITS = twc_pkg::SAMPLE_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  twc_in_if.sink         in_ch,
  output twc_pkg::item_t q_data,
  output logic           q_valid,
  input  logic           q_ready
);

  localparam int MW  = SAMPLE_BITS;
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int RW  = SAMPLE_BITS + 8;
  localparam int CW  = SAMPLE_BITS + 11;
  localparam int SCW = $clog2(RW + 1);
  localparam int CNW = twc_pkg::STEP_W + 1;
  localparam int ZW  = twc_pkg::ZW;
  localparam logic [SCW-1:0] ROOT_STEPS = SCW'(RW);
  localparam logic [CNW-1:0] CORDIC_END = CNW'(twc_pkg::CORDIC_STEPS);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_SQ    = 3'd1;
  localparam logic [2:0] F_LOAD  = 3'd2;
  localparam logic [2:0] F_ROLL  = 3'd3;
  localparam logic [2:0] F_ROOT  = 3'd4;
  localparam logic [2:0] F_PITCH = 3'd5;
  localparam logic [2:0] F_PUSH  = 3'd6;

  logic [2:0]                   state_r;
  logic [MW-1:0]                ax_r, ay_r, az_r;
  logic                         zneg_r;
  logic [SQW-1:0]               sqy_r, sqz_r;
  logic [2*RW-1:0]              rad_r;
  logic [RW+1:0]                rem_r;
  logic [RW-1:0]                root_r;
  logic [SCW-1:0]               sq_cnt_r;
  logic signed [CW-1:0]         cx_r, cy_r;
  logic signed [ZW-1:0]         cz_r;
  logic [CNW-1:0]               step_r;
  logic                         azero_r, bzero_r;
  logic [twc_pkg::ROLL_W-1:0]   roll_r;
  logic [twc_pkg::PITCH_W-1:0]  pitch_r;

  logic [MW-1:0]        mx, my, mz;
  logic [RW+1:0]        rem_t, trial, rem_nxt;
  logic [RW-1:0]        root_nxt;
  logic                 sq_run;
  logic signed [CW-1:0] dx, dy, cx_nxt, cy_nxt;
  logic signed [ZW-1:0] cz_nxt, ang, quad, roll_raw;
  logic signed [ZW-1:0] atan_v;
  logic [RW-1:0]        roll_a, roll_b, pitch_a;

  assign mx = in_ch.accel_x[MW-1] ? MW'(-in_ch.accel_x) : MW'(in_ch.accel_x);
  assign my = in_ch.accel_y[MW-1] ? MW'(-in_ch.accel_y) : MW'(in_ch.accel_y);
  assign mz = in_ch.accel_z[MW-1] ? MW'(-in_ch.accel_z) : MW'(in_ch.accel_z);

  assign in_ch.ready = (state_r == F_IDLE);
  assign q_valid     = (state_r == F_PUSH);
  assign q_data      = '{pitch: pitch_r, roll: roll_r};

  assign roll_a  = {ay_r, 8'd0};
  assign roll_b  = {az_r, 8'd0};
  assign pitch_a = {ax_r, 8'd0};

  // square root, one result bit per cycle
  always_comb begin
    rem_t = {rem_r[RW-1:0], rad_r[2*RW-1 -: 2]};
    trial = {root_r, 2'b01};
    if (rem_t >= trial) begin
      rem_nxt  = rem_t - trial;
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_t;
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  assign sq_run = (sq_cnt_r != ROOT_STEPS);

  // cordic vectoring step
  always_comb begin
    atan_v = twc_pkg::atan_entry(step_r[twc_pkg::STEP_W-1:0]);
    dx = cy_r >>> step_r[twc_pkg::STEP_W-1:0];
    dy = cx_r >>> step_r[twc_pkg::STEP_W-1:0];
    if (!cy_r[CW-1]) begin
      cx_nxt = cx_r + dx;
      cy_nxt = cy_r - dy;
      cz_nxt = cz_r + atan_v;
    end else begin
      cx_nxt = cx_r - dx;
      cy_nxt = cy_r + dy;
      cz_nxt = cz_r - atan_v;
    end
  end

  // special cases and clamp
  always_comb begin
    if (cz_r < 0)
      ang = '0;
    else if (cz_r > twc_pkg::QUARTER_TURN)
      ang = twc_pkg::QUARTER_TURN;
    else
      ang = cz_r;
    if (azero_r)
      quad = '0;
    else if (bzero_r)
      quad = twc_pkg::QUARTER_TURN;
    else
      quad = ang;
    roll_raw = zneg_r ? (twc_pkg::HALF_TURN - quad) : quad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE:  if (in_ch.valid) state_r <= F_SQ;
        F_SQ:    state_r <= F_LOAD;
        F_LOAD:  state_r <= F_ROLL;
        F_ROLL:  if (step_r == CORDIC_END) state_r <= F_ROOT;
        F_ROOT:  if (!sq_run) state_r <= F_PITCH;
        F_PITCH: if (step_r == CORDIC_END) state_r <= F_PUSH;
        F_PUSH:  if (q_ready) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        ax_r   <= mx;
        ay_r   <= my;
        az_r   <= mz;
        zneg_r <= in_ch.accel_z[MW-1];
      end
      F_SQ: begin
        sqy_r <= SQW'(ay_r * ay_r);
        sqz_r <= SQW'(az_r * az_r);
      end
      F_LOAD: begin
        rad_r    <= {sqy_r + sqz_r, 16'd0};
        rem_r    <= '0;
        root_r   <= '0;
        sq_cnt_r <= '0;
        cx_r     <= CW'(roll_b);
        cy_r     <= CW'(roll_a);
        cz_r     <= '0;
        step_r   <= '0;
        azero_r  <= (ay_r == '0);
        bzero_r  <= (az_r == '0);
      end
      F_ROLL: begin
        if (sq_run) begin
          rem_r    <= rem_nxt;
          root_r   <= root_nxt;
          rad_r    <= rad_r << 2;
          sq_cnt_r <= sq_cnt_r + 1'b1;
        end
        if (step_r == CORDIC_END) begin
          roll_r <= twc_pkg::to_unit(roll_raw);
        end else begin
          cx_r   <= cx_nxt;
          cy_r   <= cy_nxt;
          cz_r   <= cz_nxt;
          step_r <= step_r + 1'b1;
        end
      end
      F_ROOT: begin
        if (sq_run) begin
          rem_r    <= rem_nxt;
          root_r   <= root_nxt;
          rad_r    <= rad_r << 2;
          sq_cnt_r <= sq_cnt_r + 1'b1;
        end else begin
          cx_r    <= CW'(root_r);
          cy_r    <= CW'(pitch_a);
          cz_r    <= '0;
          step_r  <= '0;
          azero_r <= (ax_r == '0);
          bzero_r <= (root_r == '0);
        end
      end
      F_PITCH: begin
        if (step_r == CORDIC_END) begin
          pitch_r <= twc_pkg::PITCH_W'(twc_pkg::to_unit(quad));
        end else begin
          cx_r   <= cx_nxt;
          cy_r   <= cy_nxt;
          cz_r   <= cz_nxt;
          step_r <= step_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/twc_queue.sv =====
// ----------------------------------------------------------------------------
// twc_queue: two-entry angle queue
// Decouples the angle front end from the window back end.
// ----------------------------------------------------------------------------
module twc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  twc_pkg::item_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output twc_pkg::item_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  twc_pkg::item_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== rtl/twc_back.sv =====
// ----------------------------------------------------------------------------
// twc_back: window back end
// Writes angles into the window, scans it for minima and sums, checks the
// deviation of every entry, classes the level and holds the result.
// ----------------------------------------------------------------------------
module twc_back #(
  parameter int WINDOW_DEPTH = twc_pkg::WINDOW_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twc_pkg::item_t                q_data,
  input  logic                          q_valid,
  output logic                          q_ready,
  twc_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNW  = $clog2(WINDOW_DEPTH + 1);
  localparam int PW   = twc_pkg::PITCH_W;
  localparam int RLW  = twc_pkg::ROLL_W;
  localparam int SUMW = RLW + CNW;
  localparam logic [IW-1:0]  LAST_SLOT = IW'(WINDOW_DEPTH - 1);
  localparam logic [CNW-1:0] FULL      = CNW'(WINDOW_DEPTH);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_SUM   = 2'd1;
  localparam logic [1:0] B_CHECK = 2'd2;
  localparam logic [1:0] B_OUT   = 2'd3;

  logic [PW-1:0]             pst_r [WINDOW_DEPTH];
  logic [RLW-1:0]            rst_r [WINDOW_DEPTH];
  logic [1:0]                state_r;
  logic [CNW-1:0]            fill_r;
  logic [IW-1:0]             slot_r, idx_r;
  logic [SUMW-1:0]           sum_p_r, sum_r_r;
  logic [PW-1:0]             min_p_r;
  logic [RLW-1:0]            min_r_r;
  logic                      steady_r;
  logic [twc_pkg::CFG_W-1:0] good_r, ok_r, stdy_r;
  logic                      out_valid_r;
  twc_pkg::item_t            out_item_r;
  logic [RLW-1:0]            level_r;
  logic [twc_pkg::CLASS_W-1:0] class_r;
  logic                      out_steady_r;

  logic [PW-1:0]             pe;
  logic [RLW-1:0]            re;
  logic                      last;
  logic [SUMW-1:0]           scaled_p, scaled_r, dev_p, dev_r, bound;
  logic [RLW-1:0]            level;
  logic [twc_pkg::CLASS_W-1:0] cls;
  logic                      out_load;
  logic [IW-1:0]             prev_slot;

  assign pe   = pst_r[idx_r];
  assign re   = rst_r[idx_r];
  assign last = (CNW'(idx_r) + CNW'(1)) == fill_r;

  // slot of the newest entry
  assign prev_slot = (slot_r == '0) ? LAST_SLOT : slot_r - 1'b1;

  assign scaled_p = SUMW'(fill_r * pe);
  assign scaled_r = SUMW'(fill_r * re);
  assign bound    = SUMW'(fill_r * stdy_r);
  assign dev_p    = (sum_p_r > scaled_p) ? (sum_p_r - scaled_p) : (scaled_p - sum_p_r);
  assign dev_r    = (sum_r_r > scaled_r) ? (sum_r_r - scaled_r) : (scaled_r - sum_r_r);

  always_comb begin
    level = (RLW'(min_p_r) > min_r_r) ? RLW'(min_p_r) : min_r_r;
    if (level > ok_r)
      cls = twc_pkg::CLASS_BAD;
    else if (level > good_r)
      cls = twc_pkg::CLASS_OK;
    else
      cls = twc_pkg::CLASS_GOOD;
  end

  assign q_ready  = (state_r == B_IDLE);
  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pitch_angle  = out_item_r.pitch;
  assign out_ch.roll_angle   = out_item_r.roll;
  assign out_ch.window_level = level_r;
  assign out_ch.tilt_class   = class_r;
  assign out_ch.steady       = out_steady_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      good_r      <= twc_pkg::GOOD_LIMIT_RST;
      ok_r        <= twc_pkg::OK_LIMIT_RST;
      stdy_r      <= twc_pkg::STEADY_LIMIT_RST;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          twc_pkg::CFG_GOOD_LIMIT:   good_r <= cfg_data;
          twc_pkg::CFG_OK_LIMIT:     ok_r   <= cfg_data;
          twc_pkg::CFG_STEADY_LIMIT: stdy_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            slot_r  <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
            if (fill_r != FULL) fill_r <= fill_r + 1'b1;
            state_r <= B_SUM;
          end
        end
        B_SUM:   if (last) state_r <= B_CHECK;
        B_CHECK: if (last) state_r <= B_OUT;
        B_OUT:   if (out_load) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pst_r[slot_r] <= q_data.pitch;
          rst_r[slot_r] <= q_data.roll;
        end
        idx_r    <= '0;
        sum_p_r  <= '0;
        sum_r_r  <= '0;
        min_p_r  <= '1;
        min_r_r  <= '1;
        steady_r <= 1'b1;
      end
      B_SUM: begin
        sum_p_r <= sum_p_r + SUMW'(pe);
        sum_r_r <= sum_r_r + SUMW'(re);
        if (pe < min_p_r) min_p_r <= pe;
        if (re < min_r_r) min_r_r <= re;
        idx_r <= last ? '0 : idx_r + 1'b1;
      end
      B_CHECK: begin
        if (dev_p > bound || dev_r > bound) steady_r <= 1'b0;
        idx_r <= idx_r + 1'b1;
      end
      B_OUT: begin
        if (out_load) begin
          out_item_r.pitch <= pst_r[prev_slot];
          out_item_r.roll  <= rst_r[prev_slot];
          level_r          <= level;
          class_r          <= cls;
          out_steady_r     <= steady_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/tilt_window_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// tilt_window_classifier_unit: accelerometer tilt classifier
// Absolute pitch and roll of each sample, window minima, class and steadiness.
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one signed x, y, z sample per transfer (valid/ready).
//   out_ch gives one result per sample, in order: pitch and roll of that
//   sample, the larger of the window minima, its class and the steady flag.
//   cfg_wr_en/cfg_index/cfg_data write good, ok and steady limits; write
//   them only while no sample is in flight.
// processing
//   the front end works on one sample at a time, paced by the bit-serial
//   square root and the shared cordic unit, which runs sixteen steps for
//   roll and sixteen for pitch; the window scan then sums and minimises the
//   window, checks the deviation of each entry and registers the result.
// reset and stall
//   reset empties the window and queue and loads the default limits.
//   a stalled receiver holds the result register; a two-entry queue lets
//   the front end keep accepting until it fills, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module tilt_window_classifier_unit #(
  parameter int WINDOW_DEPTH = twc_pkg::WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = twc_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  twc_in_if.sink                        in_ch,
  twc_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twc_pkg::CFG_W-1:0]     cfg_data
);

  twc_pkg::item_t f_data, b_data;
  logic           f_valid, f_ready, b_valid, b_ready;

  twc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (f_data),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  twc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (f_data),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (b_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  twc_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (b_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
